// ===== rtl/core/three_term_recurrence_checksum_unit_macros.svh =====
// assertion helpers for the recurrence checksum unit
`ifndef THREE_TERM_RECURRENCE_CHECKSUM_UNIT_MACROS_SVH
`define THREE_TERM_RECURRENCE_CHECKSUM_UNIT_MACROS_SVH

// clocked check, masked while reset is held
`define TTRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define TTRC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/ttrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttrc_pkg
// Constants and modular helpers for the three-term recurrence checksum.
// ----------------------------------------------------------------------------
package ttrc_pkg;

    localparam int unsigned TERM_W = 16;
    localparam int unsigned POS_W  = 8;
    localparam int unsigned PROD_W = 25;   // 9-bit factor times 16-bit term

    localparam logic [7:0]        SEED_OFFSET = 8'd7;
    localparam logic [7:0]        ALPHA_STEP  = 8'd17;
    localparam logic [7:0]        BETA_STEP   = 8'd31;
    localparam logic [TERM_W:0]   MODULUS     = 17'd65535;
    localparam logic [TERM_W-1:0] TERM_RESET  = 16'd1;

    // x mod 65535 for x below 2^25: fold high bits onto low, one correction
    function automatic logic [TERM_W-1:0] mod_fold(input logic [PROD_W-1:0] x);
        logic [TERM_W:0] s;
        s = {1'b0, x[TERM_W-1:0]} + {8'b0, x[PROD_W-1:TERM_W]};
        if (s >= MODULUS) begin
            s = s - MODULUS;
        end
        return s[TERM_W-1:0];
    endfunction

endpackage

// ===== rtl/core/three_term_recurrence_checksum_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_term_recurrence_checksum_unit
// Byte-serial checksum built on a two-term modular recurrence.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one message byte per request
//   with first and last markers. A first byte restarts the recurrence; a
//   byte marked last produces one checksum request on the output channel
//   (o_valid / i_stall). Bytes without the last marker produce nothing.
//   A byte passes from the input register to the term registers and, if last,
//   to the output register. Throughput: one byte per cycle while no last byte
//   waits; the recurrence step (two small multiplies and a fold modulo 65535)
//   is combinational between the input register and the term registers.
//   Receiver stall: the output register holds its checksum; bytes without
//   the last marker keep flowing, and a last byte waits in the input
//   register, raising o_stall, until the output register frees up.
//   Reset: both terms return to one, the position to zero, and both
//   pipeline registers empty. A byte before any first byte continues from
//   that reset state.
// ----------------------------------------------------------------------------
`include "three_term_recurrence_checksum_unit_macros.svh"

module three_term_recurrence_checksum_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_checksum
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_first;
    logic       r_in_last;

    // recurrence state
    logic [ttrc_pkg::TERM_W-1:0] r_prev, n_prev;
    logic [ttrc_pkg::TERM_W-1:0] r_cur,  n_cur;
    logic [ttrc_pkg::POS_W-1:0]  r_pos,  n_pos;

    // output register
    logic                        r_out_valid;
    logic [ttrc_pkg::TERM_W-1:0] r_out_sum;

    logic                        out_free;
    logic                        s1_go;
    logic                        in_free;
    logic [ttrc_pkg::POS_W-1:0]  pos_inc;
    logic [7:0]                  alpha;
    logic [7:0]                  beta;
    logic [8:0]                  factor;
    logic [ttrc_pkg::PROD_W-1:0] prod_a;
    logic [ttrc_pkg::PROD_W-1:0] prod_b;
    logic                        neg;
    logic [ttrc_pkg::PROD_W-1:0] mag;
    logic [ttrc_pkg::TERM_W-1:0] folded;
    logic [ttrc_pkg::TERM_W-1:0] step_term;

    // only a last byte needs room in the output register
    assign out_free = !r_out_valid || !i_stall;
    assign s1_go    = r_in_valid && (!r_in_last || out_free);
    assign in_free  = !r_in_valid || s1_go;
    assign o_stall  = !in_free;

    assign o_valid    = r_out_valid;
    assign o_checksum = r_out_sum;

    always_comb begin
        pos_inc = r_pos + 8'd1;
        alpha   = 8'(ttrc_pkg::ALPHA_STEP * pos_inc);
        beta    = 8'(ttrc_pkg::BETA_STEP * pos_inc);
        factor  = {1'b0, r_in_byte} + {1'b0, alpha};
        prod_a  = ttrc_pkg::PROD_W'(factor) * ttrc_pkg::PROD_W'(r_cur);
        prod_b  = ttrc_pkg::PROD_W'(beta) * ttrc_pkg::PROD_W'(r_prev);
        neg     = prod_a < prod_b;
        // negative difference reduced as a 64-bit wrap would be: result is (d + 1) mod 65535
        mag     = neg ? (prod_b - prod_a - 25'd1) : (prod_a - prod_b);
        folded  = ttrc_pkg::mod_fold(mag);
        if (neg && folded != '0) begin
            step_term = ttrc_pkg::MODULUS[ttrc_pkg::TERM_W-1:0] - folded;
        end else begin
            step_term = folded;
        end

        n_prev = r_prev;
        n_cur  = r_cur;
        n_pos  = r_pos;
        if (s1_go) begin
            if (r_in_first) begin
                n_prev = ttrc_pkg::TERM_RESET;
                n_cur  = {8'b0, r_in_byte} + {8'b0, ttrc_pkg::SEED_OFFSET};
                n_pos  = '0;
            end else begin
                n_prev = r_cur;
                n_cur  = step_term;
                n_pos  = pos_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= ttrc_pkg::TERM_RESET;
            r_cur       <= ttrc_pkg::TERM_RESET;
            r_pos       <= '0;
        end else begin
            r_prev <= n_prev;
            r_cur  <= n_cur;
            r_pos  <= n_pos;
            if (in_free) begin
                r_in_valid <= i_valid;
            end
            if (s1_go && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_valid) begin
            r_in_byte  <= i_byte_value;
            r_in_first <= i_first_byte;
            r_in_last  <= i_last_byte;
        end
        if (s1_go && r_in_last) begin
            r_out_sum <= n_cur;
        end
    end

    `TTRC_ASSERT(a_sum_range, r_out_valid |-> r_out_sum != 16'hFFFF, "checksum out of range")
    `TTRC_ASSERT(a_stall_cause, o_stall |-> r_in_last && r_out_valid && i_stall, "bad stall")
    `TTRC_ASSERT(a_restart, s1_go && r_in_first |=> r_prev == ttrc_pkg::TERM_RESET, "no restart")
    `TTRC_ASSERT(a_restart_pos, s1_go && r_in_first |=> r_pos == '0, "position not cleared")
    `TTRC_ASSERT(a_hold, r_out_valid && i_stall |=> r_out_valid && $stable(r_out_sum), "dropped")

endmodule

// ===== verif/three_term_recurrence_checksum_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_term_recurrence_checksum_unit_test
// Self-checking bench for the recurrence checksum unit. Byte requests go in
// through the valid/stall input channel while a local model of the two-term
// recurrence predicts each checksum. A monitor compares every checksum
// request on the output channel with the oldest prediction. Traffic is a
// directed set of corner cases, then mostly well-formed random messages with
// some broken framing, under changing sender and receiver idle rates. One
// long receiver hold-off backs the unit up until it stalls its input, and one long message wraps the position.
// ----------------------------------------------------------------------------
module three_term_recurrence_checksum_unit_test;

    localparam int unsigned CLK_HALF      = 5;
    localparam int unsigned RESET_CYCLES  = 4;
    localparam int unsigned WATCHDOG_MAX  = 5000;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned PHASE_ITEMS   = 500;

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_valid      = 1'b0;
    logic [7:0]                  i_byte_value = '0;
    logic                        i_first_byte = 1'b0;
    logic                        i_last_byte  = 1'b0;
    logic                        i_stall      = 1'b0;
    logic                        o_stall;
    logic                        o_valid;
    logic [ttrc_pkg::TERM_W-1:0] o_checksum;

    // local copy of the recurrence state
    logic [ttrc_pkg::TERM_W-1:0] prev_term;
    logic [ttrc_pkg::TERM_W-1:0] cur_term;
    logic [ttrc_pkg::POS_W-1:0]  byte_pos;

    logic [ttrc_pkg::TERM_W-1:0] pending_checksums[$];
    logic [ttrc_pkg::TERM_W-1:0] want_checksum;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned bytes_sent    = 0;
    int unsigned error_count   = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned hold_left     = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_started = 0;

    three_term_recurrence_checksum_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_byte_value (i_byte_value),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_checksum   (o_checksum)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // one step of the recurrence, difference taken as a wrapping 64-bit value
    function automatic logic [ttrc_pkg::TERM_W-1:0] recurrence_term(
            input logic [7:0] value,
            input logic [ttrc_pkg::POS_W-1:0] idx,
            input logic [ttrc_pkg::TERM_W-1:0] cur,
            input logic [ttrc_pkg::TERM_W-1:0] prev);
        logic [7:0]  alpha;
        logic [7:0]  beta;
        logic [63:0] gain;
        logic [63:0] loss;
        logic [63:0] rem;
        alpha = ttrc_pkg::ALPHA_STEP * idx;
        beta  = ttrc_pkg::BETA_STEP * idx;
        gain  = (64'(value) + 64'(alpha)) * 64'(cur);
        loss  = 64'(beta) * 64'(prev);
        if (gain >= loss) begin
            return ttrc_pkg::TERM_W'((gain - loss) % 64'(ttrc_pkg::MODULUS));
        end
        // negative difference reduces as (d + 1) mod 65535
        rem = (loss - gain - 64'd1) % 64'(ttrc_pkg::MODULUS);
        if (rem == 64'd0) begin
            return '0;
        end
        return ttrc_pkg::TERM_W'(64'(ttrc_pkg::MODULUS) - rem);
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic is_first,
                             input logic is_last);
        logic [ttrc_pkg::TERM_W-1:0] next_term;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_byte_value <= value;
        i_first_byte <= is_first;
        i_last_byte  <= is_last;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        if (is_first) begin
            prev_term = ttrc_pkg::TERM_RESET;
            cur_term  = ttrc_pkg::TERM_W'(value) + ttrc_pkg::TERM_W'(ttrc_pkg::SEED_OFFSET);
            byte_pos  = '0;
        end else begin
            byte_pos  = byte_pos + 1'b1;
            next_term = recurrence_term(value, byte_pos, cur_term, prev_term);
            prev_term = cur_term;
            cur_term  = next_term;
        end
        if (is_last) begin
            pending_checksums.push_back(cur_term);
        end
        bytes_sent++;
    endtask

    task automatic send_message(input int unsigned len, input bit with_last);
        for (int unsigned k = 0; k < len; k++) begin
            send_byte(8'($urandom_range(255)), k == 0, with_last && (k == len - 1));
        end
    endtask

    task automatic test_directed();
        // a byte before any first byte runs on the reset state
        send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b1);
        // one- and two-byte messages at both ends of the byte range
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        // recurrence keeps running after a last byte with no new first byte
        send_byte(8'h80, 1'b0, 1'b1);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'hFE, 1'b0, 1'b1);
        // an unfinished message cut off by a new first byte
        send_byte(8'h10, 1'b1, 1'b0);
        send_byte(8'h20, 1'b1, 1'b1);
        send_byte(8'h33, 1'b1, 1'b0);
        send_byte(8'hCC, 1'b0, 1'b0);
        send_byte(8'h0F, 1'b0, 1'b1);
    endtask

    task automatic test_position_wrap();
        // long enough that the position counter rolls over
        send_message($urandom_range(300, 520), 1'b1);
    endtask

    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = bytes_sent + n_items;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
                send_message($urandom_range(1, 12), 1'b1);
            end else if (pick < 86) begin
                send_message($urandom_range(13, 60), 1'b1);
            end else if (pick < 87) begin
                send_message($urandom_range(256, 300), 1'b1);
            end else if (pick < 93) begin
                send_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            end else if (pick < 97) begin
                send_message($urandom_range(1, 8), 1'b0);
            end else begin
                // continuation bytes with no first marker
                for (int unsigned k = $urandom_range(1, 5); k > 0; k--) begin
                    send_byte(8'($urandom_range(255)), 1'b0, k == 1);
                end
            end
        end
    endtask

    task automatic test_backpressure();
        hold_requests++;
        for (int unsigned k = 0; k < 40; k++) begin
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                      $urandom_range(99) < 60);
        end
    endtask

    // receiver side: random stall, or a long hold-off when one is asked for
    always @(negedge i_clk) begin
        if (holds_started != hold_requests) begin
            holds_started = hold_requests;
            hold_left     = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_checksums.size() == 0) begin
                $error("checksum: expected none, actual %0d", o_checksum);
                error_count++;
            end else begin
                want_checksum = pending_checksums.pop_front();
                if (o_checksum !== want_checksum) begin
                    $error("checksum: expected %0d, actual %0d", want_checksum, o_checksum);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        prev_term = ttrc_pkg::TERM_RESET;
        cur_term  = ttrc_pkg::TERM_RESET;
        byte_pos  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 22;
        recv_idle_pct = 88;
        test_directed();
        test_random_traffic(PHASE_ITEMS);

        send_idle_pct = 88;
        recv_idle_pct = 22;
        test_random_traffic(PHASE_ITEMS / 2);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_position_wrap();
        test_random_traffic(PHASE_ITEMS / 2);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_checksums.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ttrc_pkg.sv
rtl/core/three_term_recurrence_checksum_unit.sv
verif/three_term_recurrence_checksum_unit_test.sv
